### hdl/pmmr_pkg.sv
// ----------------------------------------------------------------------------
// pmmr_pkg
// shared constants and types for the min/max pixel rescale block
// ----------------------------------------------------------------------------
package pmmr_pkg;

    localparam int OUT_BITS = 16;
    localparam int PIX_W    = 16;
    localparam int CNT_W    = $clog2(OUT_BITS + 1);

    localparam logic [PIX_W:0] PIX_MAX = (PIX_W + 1)'((64'd1 << OUT_BITS) - 64'd1);
    localparam logic [31:0]    PIX_RANGE = 32'((64'd1 << OUT_BITS));

    localparam logic signed [31:0] MIN_RESET = 32'sh7fff_ffff;
    localparam logic signed [31:0] MAX_RESET = 32'sh8000_0000;
    localparam logic signed [31:0] S16_ICPT  = -32'sd32768;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_MEASURE = 2'd1,
        OP_CONVERT = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        WT_S32 = 2'd0,
        WT_S16 = 2'd1,
        WT_U8  = 2'd2,
        WT_RSV = 2'd3
    } word_type_t;

    typedef enum logic {
        REG_WORD_TYPE  = 1'b0,
        REG_BIG_ENDIAN = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CALC  = 2'd1,
        ST_CHECK = 2'd2,
        ST_DIV   = 2'd3
    } state_t;

endpackage

### hdl/pmmr_div.sv
// ----------------------------------------------------------------------------
// pmmr_div
// bit-serial restoring divider, one quotient bit per cycle
// computes floor((dividend << OUT_BITS) / divisor) for dividend < divisor
// ----------------------------------------------------------------------------
module pmmr_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [31:0]                      dividend,
    input  logic [31:0]                      divisor,
    output logic [pmmr_pkg::OUT_BITS-1:0]    quotient,
    output logic                             done
);

    logic [31:0]                   rem_reg;
    logic [31:0]                   rem_next;
    logic [31:0]                   div_reg;
    logic [pmmr_pkg::OUT_BITS-1:0] quo_reg;
    logic [pmmr_pkg::OUT_BITS-1:0] quo_next;
    logic [pmmr_pkg::CNT_W-1:0]    cnt_reg;
    logic [pmmr_pkg::CNT_W-1:0]    cnt_next;
    logic                          done_reg;
    logic                          done_next;
    logic [32:0]                   shifted;
    logic [32:0]                   trial;

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        trial     = shifted - {1'b0, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = dividend;
            cnt_next = pmmr_pkg::CNT_W'(pmmr_pkg::OUT_BITS);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[pmmr_pkg::OUT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[pmmr_pkg::OUT_BITS-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - pmmr_pkg::CNT_W'(1);
            done_next = (cnt_reg == pmmr_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### hdl/pixel_min_max_rescale_u16.sv
// ----------------------------------------------------------------------------
// pixel_min_max_rescale_u16
// converts raw samples to unsigned 16-bit pixels with min/max tracking
// ----------------------------------------------------------------------------
// clear and measure transactions: no result, busy stays low
// convert in 16-bit, 8-bit or reserved mode: result strobe in the cycle after accept
// convert in 32-bit mode: CALC then CHECK, result set in CHECK without division,
// else via DIV, waiting on the bit-serial divider producing one bit per cycle
// one item at a time; the result receiver cannot stall
// rst_n clears configuration, min/max tracking and control state
// ----------------------------------------------------------------------------
module pixel_min_max_rescale_u16
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     op,
    input  logic [31:0]                    raw_word,
    output logic                           done,
    output logic [pmmr_pkg::PIX_W-1:0]     pixel,
    output logic signed [31:0]             intercept,
    output logic [31:0]                    value_range,
    output logic                           clipped
);

    pmmr_pkg::state_t              state_reg;
    pmmr_pkg::state_t              state_next;
    logic [1:0]                    word_type_reg;
    logic                          big_endian_reg;
    logic signed [31:0]            min_reg;
    logic signed [31:0]            min_next;
    logic signed [31:0]            max_reg;
    logic signed [31:0]            max_next;
    logic signed [31:0]            x_reg;
    logic signed [31:0]            x_next;
    logic [31:0]                   d_reg;
    logic [31:0]                   d_next;
    logic [31:0]                   range_reg;
    logic [31:0]                   range_next;
    logic                          range_ok_reg;
    logic                          range_ok_next;
    logic                          d_ok_reg;
    logic                          d_ok_next;
    logic                          done_reg;
    logic                          done_next;
    logic [pmmr_pkg::PIX_W-1:0]    pixel_reg;
    logic [pmmr_pkg::PIX_W-1:0]    pixel_next;
    logic signed [31:0]            intercept_reg;
    logic signed [31:0]            intercept_next;
    logic [31:0]                   value_range_reg;
    logic [31:0]                   value_range_next;
    logic                          clipped_reg;
    logic                          clipped_next;
    logic                          accept;
    logic                          cfg_write;
    logic signed [31:0]            x_dec;
    logic [31:0]                   swap32;
    logic [15:0]                   raw16;
    logic [pmmr_pkg::PIX_W:0]      narrow_pix;
    logic                          div_start;
    logic                          div_done;
    logic [pmmr_pkg::OUT_BITS-1:0] div_quo;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign accept    = start && !busy;
    assign busy      = (state_reg != pmmr_pkg::ST_IDLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_type_reg  <= pmmr_pkg::WT_S32;
            big_endian_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (pmmr_pkg::reg_index_t'(paddr[2]))
                pmmr_pkg::REG_WORD_TYPE:  word_type_reg  <= pwdata[1:0];
                pmmr_pkg::REG_BIG_ENDIAN: big_endian_reg <= pwdata[0];
                default:                  word_type_reg  <= word_type_reg;
            endcase
        end
    end

    always_comb
    begin
        case (pmmr_pkg::reg_index_t'(paddr[2]))
            pmmr_pkg::REG_WORD_TYPE:  prdata = {30'd0, word_type_reg};
            pmmr_pkg::REG_BIG_ENDIAN: prdata = {31'd0, big_endian_reg};
            default:                  prdata = '0;
        endcase
    end

    // sample decode
    always_comb
    begin
        swap32 = big_endian_reg ? {raw_word[7:0], raw_word[15:8], raw_word[23:16],
                                   raw_word[31:24]} : raw_word;
        raw16  = big_endian_reg ? {raw_word[7:0], raw_word[15:8]} : raw_word[15:0];
        case (pmmr_pkg::word_type_t'(word_type_reg))
            pmmr_pkg::WT_S32: x_dec = swap32;
            pmmr_pkg::WT_S16: x_dec = {{16{raw16[15]}}, raw16};
            default:          x_dec = {24'd0, raw_word[7:0]};
        endcase
        if (pmmr_pkg::word_type_t'(word_type_reg) == pmmr_pkg::WT_S16)
        begin
            narrow_pix = {1'b0, raw16 ^ 16'h8000};
        end
        else
        begin
            narrow_pix = {9'd0, raw_word[7:0]};
        end
    end

    pmmr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (d_reg),
        .divisor  (range_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_comb
    begin
        state_next       = state_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        x_next           = x_reg;
        d_next           = d_reg;
        range_next       = range_reg;
        range_ok_next    = range_ok_reg;
        d_ok_next        = d_ok_reg;
        done_next        = 1'b0;
        pixel_next       = pixel_reg;
        intercept_next   = intercept_reg;
        value_range_next = value_range_reg;
        clipped_next     = clipped_reg;
        div_start        = 1'b0;
        case (state_reg)
            pmmr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (pmmr_pkg::op_t'(op))
                        pmmr_pkg::OP_CLEAR:
                        begin
                            min_next = pmmr_pkg::MIN_RESET;
                            max_next = pmmr_pkg::MAX_RESET;
                        end
                        pmmr_pkg::OP_MEASURE:
                        begin
                            if (x_dec < min_reg)
                            begin
                                min_next = x_dec;
                            end
                            if (x_dec > max_reg)
                            begin
                                max_next = x_dec;
                            end
                        end
                        pmmr_pkg::OP_CONVERT:
                        begin
                            if (pmmr_pkg::word_type_t'(word_type_reg) == pmmr_pkg::WT_S32)
                            begin
                                x_next     = x_dec;
                                state_next = pmmr_pkg::ST_CALC;
                            end
                            else
                            begin
                                done_next        = 1'b1;
                                value_range_next = pmmr_pkg::PIX_RANGE;
                                intercept_next   = (pmmr_pkg::word_type_t'(word_type_reg)
                                                    == pmmr_pkg::WT_S16) ?
                                                   pmmr_pkg::S16_ICPT : 32'sd0;
                                if (narrow_pix > pmmr_pkg::PIX_MAX)
                                begin
                                    pixel_next   = pmmr_pkg::PIX_MAX[pmmr_pkg::PIX_W-1:0];
                                    clipped_next = 1'b1;
                                end
                                else
                                begin
                                    pixel_next   = narrow_pix[pmmr_pkg::PIX_W-1:0];
                                    clipped_next = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = pmmr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            pmmr_pkg::ST_CALC:
            begin
                range_ok_next = (max_reg >= min_reg);
                range_next    = max_reg - min_reg;
                d_ok_next     = (x_reg >= min_reg);
                d_next        = x_reg - min_reg;
                state_next    = pmmr_pkg::ST_CHECK;
            end
            pmmr_pkg::ST_CHECK:
            begin
                intercept_next   = min_reg;
                value_range_next = range_ok_reg ? range_reg : 32'd0;
                if (!range_ok_reg || (range_reg == 32'd0) || !d_ok_reg)
                begin
                    pixel_next   = '0;
                    clipped_next = 1'b0;
                    done_next    = 1'b1;
                    state_next   = pmmr_pkg::ST_IDLE;
                end
                else if (d_reg >= range_reg)
                begin
                    pixel_next   = pmmr_pkg::PIX_MAX[pmmr_pkg::PIX_W-1:0];
                    clipped_next = 1'b1;
                    done_next    = 1'b1;
                    state_next   = pmmr_pkg::ST_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = pmmr_pkg::ST_DIV;
                end
            end
            pmmr_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    pixel_next   = pmmr_pkg::PIX_W'(div_quo);
                    clipped_next = 1'b0;
                    done_next    = 1'b1;
                    state_next   = pmmr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pmmr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmmr_pkg::ST_IDLE;
            min_reg   <= pmmr_pkg::MIN_RESET;
            max_reg   <= pmmr_pkg::MAX_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            done_reg  <= done_next;
        end
    end

    // datapath and result registers
    always_ff @(posedge clk)
    begin
        x_reg           <= x_next;
        d_reg           <= d_next;
        range_reg       <= range_next;
        range_ok_reg    <= range_ok_next;
        d_ok_reg        <= d_ok_next;
        pixel_reg       <= pixel_next;
        intercept_reg   <= intercept_next;
        value_range_reg <= value_range_next;
        clipped_reg     <= clipped_next;
    end

    assign done        = done_reg;
    assign pixel       = pixel_reg;
    assign intercept   = intercept_reg;
    assign value_range = value_range_reg;
    assign clipped     = clipped_reg;

endmodule
